[hw/rtl/sweh_pkg.sv]
`default_nettype none
package sweh_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_RADIUS = 7;
	localparam int DEF_PIXEL_BITS = 12;

	localparam int WIDTH_BITS  = 11;
	localparam int HEIGHT_BITS = 16;
	localparam int RADIUS_BITS = 3;
	localparam int LEVEL_BITS  = 17;
	localparam int EQ_BITS     = 16;
	localparam int ADDR_BITS   = 4;
	localparam int DATA_BITS   = 32;

	localparam logic [WIDTH_BITS-1:0]  RST_WIDTH  = 11'd1024;
	localparam logic [HEIGHT_BITS-1:0] RST_HEIGHT = 16'd1024;
	localparam logic [RADIUS_BITS-1:0] RST_RADIUS = 3'd3;
	localparam logic [LEVEL_BITS-1:0]  RST_LEVELS = 17'd256;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_RADIUS = 2'd2,
		REG_LEVELS = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CTR,
		ST_CTRW,
		ST_SCAN,
		ST_LAST,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

[hw/rtl/sliding_window_hist_equalizer.sv]
`default_nettype none
// Local histogram equalizer over a square window of side 2*radius+1 on a raster pixel
// stream. Each accepted frame pixel (s_tuser low) is written to a line store;
// once the stream is radius rows plus radius pixels ahead, the item yields the result for
// the next centre pixel in raster order, last one marked with m_tlast. After a frame's
// pixels, send radius*width+radius items (drain or not) to flush. Each result is computed
// before the next item is taken: the window is read from the single line store port one
// pixel per cycle, then the ratio passes a chain of restoring division cells, one quotient
// bit per cell. Items that give no result leave the input ready. Any register write
// restarts the frame; write registers only while idle.
module sliding_window_hist_equalizer
	import sweh_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_RADIUS = DEF_MAX_RADIUS,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS,
	localparam int TDW = ((PIXEL_BITS + 7) / 8) * 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ADDR_BITS-1:0] paddr,
	input  wire logic [DATA_BITS-1:0] pwdata,
	output logic      [DATA_BITS-1:0] prdata,
	output logic                      pready,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [TDW-1:0]       s_tdata,  // pixel
	input  wire logic                 s_tuser,  // drain
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [15:0]          m_tdata,  // equalized
	output logic                      m_tlast
);
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RB  = $clog2(2 * MAX_RADIUS + 2);
	localparam int AW  = RB + CW;
	localparam int XW  = ((CW > WIDTH_BITS) ? CW : WIDTH_BITS) + 1;
	localparam int YW  = HEIGHT_BITS + 1;
	localparam int RW  = $clog2(MAX_RADIUS + 1);
	localparam int SQ  = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
	localparam int DB  = $clog2(SQ + 1);
	localparam int NB  = DB + EQ_BITS;
	localparam int PW  = HEIGHT_BITS + XW + 1;

	logic [WIDTH_BITS-1:0]  width_q;
	logic [HEIGHT_BITS-1:0] height_q;
	logic [RADIUS_BITS-1:0] radius_q;
	logic [LEVEL_BITS-1:0]  levels_q;

	state_t state_q, state_d;

	logic [PW-1:0]          pos_q;
	logic [CW-1:0]          in_col_q;
	logic [RB-1:0]          in_row_q;
	logic [HEIGHT_BITS-1:0] orow_q;
	logic [CW-1:0]          ocol_q;
	logic [YW-1:0]          sr_q, re_q;
	logic [XW-1:0]          sc_q, cs_q, ce_q;
	logic [PIXEL_BITS-1:0]  ctr_q, min_q;
	logic                   have_min_q, rd_s1;
	logic [DB-1:0]          cdf_q, cnt_q, den_q;
	logic [NB-1:0]          num_q;
	logic [EQ_BITS-1:0]     eq_q;
	logic                   last_q;

	logic [XW-1:0]          w_eff;
	logic [HEIGHT_BITS-1:0] h_eff;
	logic [RW-1:0]          rad;
	logic [EQ_BITS-1:0]     lm1;
	logic [PW-1:0]          total, delay;
	logic [DB-1:0]          side2;
	logic [RW:0]            side;

	logic cfg_wr, acc, adv, do_out, ram_we, div_go, div_go_s1, fin;
	logic [AW-1:0]          raddr, waddr;
	logic [PIXEL_BITS-1:0]  rdata;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			radius_q <= RST_RADIUS;
			levels_q <= RST_LEVELS;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_WIDTH:  width_q  <= pwdata[WIDTH_BITS-1:0];
				REG_HEIGHT: height_q <= pwdata[HEIGHT_BITS-1:0];
				REG_RADIUS: radius_q <= pwdata[RADIUS_BITS-1:0];
				REG_LEVELS: levels_q <= pwdata[LEVEL_BITS-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_WIDTH:  prdata = DATA_BITS'(width_q);
			REG_HEIGHT: prdata = DATA_BITS'(height_q);
			REG_RADIUS: prdata = DATA_BITS'(radius_q);
			REG_LEVELS: prdata = DATA_BITS'(levels_q);
		endcase
	end

	// clamp registers to their working ranges
	always_comb begin
		if (width_q == '0) begin
			w_eff = XW'(1);
		end else if (XW'(width_q) > XW'(MAX_WIDTH)) begin
			w_eff = XW'(MAX_WIDTH);
		end else begin
			w_eff = XW'(width_q);
		end
		h_eff = (height_q == '0) ? HEIGHT_BITS'(1) : height_q;
		rad   = (int'(radius_q) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_q);
		if (levels_q == '0) begin
			lm1 = '0;
		end else if (levels_q > LEVEL_BITS'(65536)) begin
			lm1 = '1;
		end else begin
			lm1 = EQ_BITS'(levels_q - LEVEL_BITS'(1));
		end
	end

	assign total = PW'(w_eff) * PW'(h_eff);
	assign delay = PW'(rad) * PW'(w_eff) + PW'(rad);
	assign side  = {rad, 1'b1};
	assign side2 = DB'(side) * DB'(side);

	assign acc    = s_tvalid && s_tready;
	assign adv    = acc && (!(pos_q < total) || !s_tuser);
	assign do_out = adv && (pos_q >= delay);
	assign ram_we = acc && (pos_q < total) && !s_tuser;
	assign waddr  = {in_row_q, in_col_q};

	// window bounds clipped to the image
	logic [YW-1:0] rs_c, re_c;
	logic [XW-1:0] cs_c, ce_c;
	always_comb begin
		rs_c = ({1'b0, orow_q} >= YW'(rad)) ? YW'(orow_q) - YW'(rad) : '0;
		re_c = (YW'(orow_q) + YW'(rad) >= YW'(h_eff)) ? YW'(h_eff) - YW'(1)
			: YW'(orow_q) + YW'(rad);
		cs_c = (XW'(ocol_q) >= XW'(rad)) ? XW'(ocol_q) - XW'(rad) : '0;
		ce_c = (XW'(ocol_q) + XW'(rad) >= w_eff) ? w_eff - XW'(1)
			: XW'(ocol_q) + XW'(rad);
	end

	// division cell chain
	logic          cv   [NB+1];
	logic [DB-1:0] crem [NB+1];
	logic [NB-1:0] cnum [NB+1];
	logic [NB-1:0] cquo [NB+1];
	logic [DB-1:0] cden [NB+1];

	// start the chain once numerator and denominator are registered
	assign cv[0]   = div_go_s1;
	assign crem[0] = '0;
	assign cnum[0] = num_q;
	assign cquo[0] = '0;
	assign cden[0] = den_q;

	for (genvar i = 0; i < NB; i++) begin : g_cell
		sweh_div_cell #(.NB(NB), .DB(DB)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.v_in   (cv[i]),
			.rem_in (crem[i]),
			.num_in (cnum[i]),
			.quo_in (cquo[i]),
			.den_in (cden[i]),
			.v_q    (cv[i+1]),
			.rem_q  (crem[i+1]),
			.num_q  (cnum[i+1]),
			.quo_q  (cquo[i+1]),
			.den_q  (cden[i+1])
		);
	end

	assign fin = cv[NB];

	logic [DB:0]    twice;
	logic           rnd_up;
	logic [NB-1:0]  qr;
	assign twice  = {crem[NB], 1'b0};
	assign rnd_up = (twice > {1'b0, cden[NB]})
		|| ((twice == {1'b0, cden[NB]}) && cquo[NB][0]);
	assign qr     = cquo[NB] + NB'(rnd_up);

	sweh_ram #(.WIDTH(PIXEL_BITS), .DEPTH(2 ** AW)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (s_tdata[PIXEL_BITS-1:0]),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (do_out) begin
				state_d = ST_CTR;
			end
			ST_CTR:  state_d = ST_CTRW;
			ST_CTRW: state_d = ST_SCAN;
			ST_SCAN: if (sc_q == ce_q && sr_q == re_q) begin
				state_d = ST_LAST;
			end
			ST_LAST: state_d = ST_MUL;
			ST_MUL:  state_d = ST_DIV;
			ST_DIV:  if (fin) begin
				state_d = ST_OUT;
			end
			ST_OUT:  if (m_tready) begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == ST_IDLE);
		m_tvalid = (state_q == ST_OUT);
		div_go   = (state_q == ST_MUL);
		if (state_q == ST_CTR) begin
			raddr = {orow_q[RB-1:0], ocol_q};
		end else begin
			raddr = {sr_q[RB-1:0], sc_q[CW-1:0]};
		end
	end

	assign m_tdata = eq_q;
	assign m_tlast = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pos_q     <= '0;
			in_col_q  <= '0;
			in_row_q  <= '0;
			orow_q    <= '0;
			ocol_q    <= '0;
			rd_s1     <= 1'b0;
			div_go_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_s1     <= (state_q == ST_SCAN);
			div_go_s1 <= div_go;
			if (cfg_wr) begin
				pos_q    <= '0;
				in_col_q <= '0;
				in_row_q <= '0;
				orow_q   <= '0;
				ocol_q   <= '0;
			end else begin
				if (adv) begin
					pos_q <= pos_q + PW'(1);
					if (XW'(in_col_q) + XW'(1) >= w_eff) begin
						in_col_q <= '0;
						in_row_q <= in_row_q + RB'(1);
					end else begin
						in_col_q <= in_col_q + CW'(1);
					end
				end
				if (state_q == ST_OUT && m_tready) begin
					if (last_q) begin
						pos_q    <= '0;
						in_col_q <= '0;
						in_row_q <= '0;
						orow_q   <= '0;
						ocol_q   <= '0;
					end else if (XW'(ocol_q) + XW'(1) >= w_eff) begin
						ocol_q <= '0;
						orow_q <= orow_q + HEIGHT_BITS'(1);
					end else begin
						ocol_q <= ocol_q + CW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CTR) begin
			sr_q       <= rs_c;
			re_q       <= re_c;
			sc_q       <= cs_c;
			cs_q       <= cs_c;
			ce_q       <= ce_c;
			cdf_q      <= '0;
			cnt_q      <= '0;
			have_min_q <= 1'b0;
		end
		if (state_q == ST_CTRW) begin
			ctr_q <= rdata;
		end
		if (state_q == ST_SCAN) begin
			// advance the window scan in raster order
			if (sc_q == ce_q) begin
				sc_q <= cs_q;
				sr_q <= sr_q + YW'(1);
			end else begin
				sc_q <= sc_q + XW'(1);
			end
		end
		if (rd_s1) begin
			if (rdata <= ctr_q) begin
				cdf_q <= cdf_q + DB'(1);
			end
			if (!have_min_q || rdata < min_q) begin
				min_q      <= rdata;
				cnt_q      <= DB'(1);
				have_min_q <= 1'b1;
			end else if (rdata == min_q) begin
				cnt_q <= cnt_q + DB'(1);
			end
		end
		if (state_q == ST_MUL) begin
			num_q <= NB'(cdf_q - cnt_q) * NB'(lm1);
			den_q <= side2 - cnt_q;
		end
		if (state_q == ST_DIV && fin) begin
			eq_q   <= (cden[NB] == '0) ? '0 : qr[EQ_BITS-1:0];
			last_q <= (YW'(orow_q) + YW'(1) >= YW'(h_eff))
				&& (XW'(ocol_q) + XW'(1) >= w_eff);
		end
	end
endmodule
`default_nettype wire

[hw/rtl/sweh_ram.sv]
`default_nettype none
module sweh_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 16384
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[hw/rtl/sweh_div_cell.sv]
`default_nettype none
module sweh_div_cell #(
	parameter int NB = 26,
	parameter int DB = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          v_in,
	input  wire logic [DB-1:0] rem_in,
	input  wire logic [NB-1:0] num_in,
	input  wire logic [NB-1:0] quo_in,
	input  wire logic [DB-1:0] den_in,
	output logic               v_q,
	output logic      [DB-1:0] rem_q,
	output logic      [NB-1:0] num_q,
	output logic      [NB-1:0] quo_q,
	output logic      [DB-1:0] den_q
);
	logic [DB:0] trial;
	logic        fits;

	// bring down the next numerator bit and try one subtract
	assign trial = {rem_in, num_in[NB-1]};
	assign fits  = trial >= {1'b0, den_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		rem_q <= fits ? DB'(trial - {1'b0, den_in}) : trial[DB-1:0];
		num_q <= {num_in[NB-2:0], 1'b0};
		quo_q <= {quo_in[NB-2:0], fits};
		den_q <= den_in;
	end
endmodule
`default_nettype wire

[sim/sliding_window_hist_equalizer_tb.sv]
`default_nettype none
module sliding_window_hist_equalizer_tb;
	import sweh_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_ROWS = 3 * DEF_MAX_RADIUS + 1;
	localparam int RAND_ITEMS = 1200;

	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_PIX,
		ROW_DRAIN
	} row_kind_t;

	typedef struct {
		row_kind_t  kind;
		reg_idx_t   idx;
		logic [31:0] value;
		logic [11:0] px;
		bit         typed;
		logic [15:0] t_eq;
		bit         t_last;
	} stim_row_t;

	typedef struct packed {
		logic [15:0] eq;
		logic        last;
	} eq_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 psel, penable, pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [DATA_BITS-1:0] pwdata;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;
	logic                 s_tvalid, s_tready;
	logic [15:0]          s_tdata;  // pixel (bits 11:0), zero fill above
	logic                 s_tuser;  // drain
	logic                 m_tvalid, m_tready;
	logic [15:0]          m_tdata;  // equalized
	logic                 m_tlast;

	// side information carried along with the item being offered
	bit          cur_typed;
	logic [15:0] cur_eq;
	bit          cur_last;

	bit calm;
	int mismatches;
	int items_sent;
	eq_result_t pending_eq[$];

	sliding_window_hist_equalizer dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// predictor state
	logic [11:0] line_mem [STORE_ROWS][DEF_MAX_WIDTH];
	int unsigned cfg_w, cfg_h, cfg_r, cfg_l;
	int unsigned in_r, in_c, out_r, out_c;

	function automatic int unsigned eff_w();
		if (cfg_w == 0) return 1;
		if (cfg_w > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
		return cfg_w;
	endfunction

	function automatic int unsigned eff_h();
		return (cfg_h == 0) ? 1 : cfg_h;
	endfunction

	function automatic int unsigned eff_l();
		if (cfg_l == 0) return 1;
		if (cfg_l > 65536) return 65536;
		return cfg_l;
	endfunction

	function automatic void restart_frame();
		in_r = 0;
		in_c = 0;
		out_r = 0;
		out_c = 0;
	endfunction

	function automatic void apply_reg(reg_idx_t idx, logic [31:0] val);
		case (idx)
			REG_WIDTH: begin
				cfg_w = val[WIDTH_BITS-1:0];
			end
			REG_HEIGHT: begin
				cfg_h = val[HEIGHT_BITS-1:0];
			end
			REG_RADIUS: begin
				cfg_r = val[RADIUS_BITS-1:0];
			end
			REG_LEVELS: begin
				cfg_l = val[LEVEL_BITS-1:0];
			end
		endcase
		restart_frame();
	endfunction

	function automatic logic [15:0] window_equalize(int unsigned r, int unsigned c,
			int unsigned w, int unsigned h, int unsigned rad);
		int rr, cc;
		int unsigned centre, v, cdf, cdfmin, minv, side, num, den, q, rem;
		bit have_min;
		centre = line_mem[r % STORE_ROWS][c % DEF_MAX_WIDTH];
		cdf = 0;
		cdfmin = 0;
		minv = 0;
		have_min = 0;
		for (int dy = -int'(rad); dy <= int'(rad); dy++) begin
			rr = int'(r) + dy;
			if (rr < 0 || rr >= int'(h)) continue;
			for (int dx = -int'(rad); dx <= int'(rad); dx++) begin
				cc = int'(c) + dx;
				if (cc < 0 || cc >= int'(w)) continue;
				v = line_mem[rr % STORE_ROWS][cc % DEF_MAX_WIDTH];
				if (v <= centre) cdf++;
				if (!have_min || v < minv) begin
					minv = v;
					cdfmin = 1;
					have_min = 1;
				end else if (v == minv) begin
					cdfmin++;
				end
			end
		end
		side = 2 * rad + 1;
		den = side * side - cdfmin;
		if (den == 0) return '0;
		num = (cdf - cdfmin) * (eff_l() - 1);
		q = num / den;
		rem = num % den;
		if (2 * rem > den || (2 * rem == den && q[0])) q++;
		return q[15:0];
	endfunction

	function automatic bit take_pixel(logic [11:0] px, bit drn, output eq_result_t res);
		int unsigned w, h, rad, total, delay, pos;
		w = eff_w();
		h = eff_h();
		rad = cfg_r;
		total = w * h;
		delay = rad * w + rad;
		pos = in_r * w + in_c;
		res = '0;
		if (pos < total) begin
			if (drn) return 0;
			line_mem[in_r % STORE_ROWS][in_c % DEF_MAX_WIDTH] = px;
		end else if (pos == 0) begin
			return 0;
		end
		in_c++;
		if (in_c >= w) begin
			in_c = 0;
			in_r++;
		end
		if (pos < delay) return 0;
		res.eq = window_equalize(out_r, out_c, w, h, rad);
		res.last = (out_r + 1 >= h) && (out_c + 1 >= w);
		if (res.last) begin
			restart_frame();
		end else begin
			out_c++;
			if (out_c >= w) begin
				out_c = 0;
				out_r++;
			end
		end
		return 1;
	endfunction

	// input side: predict on every accepted transfer
	always @(posedge clk) begin
		eq_result_t res;
		if (arst_n && s_tvalid && s_tready) begin
			if (take_pixel(s_tdata[11:0], s_tuser, res)) begin
				if (cur_typed) begin
					res.eq = cur_eq;
					res.last = cur_last;
				end
				pending_eq.push_back(res);
			end
		end
	end

	// output side: compare with the oldest expectation
	always @(posedge clk) begin
		eq_result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_eq.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: equalized=%0d last=%0b", m_tdata, m_tlast);
			end else begin
				e = pending_eq.pop_front();
				if (m_tdata !== e.eq || m_tlast !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected equalized=%0d last=%0b, got %0d last=%0b",
							e.eq, e.last, m_tdata, m_tlast);
				end
			end
		end
	end

	// receiver stalls
	initial begin
		int k;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			k = calm ? 0 : $urandom_range(0, 17);
			repeat (k) begin
				@(negedge clk) m_tready <= 1'b0;
			end
			@(negedge clk) m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		#200ms;
		$display("end of test: mismatches");
		$finish;
	end

	task automatic put_item(logic [11:0] px, bit drn, bit typed = 0,
			logic [15:0] t_eq = '0, bit t_last = 0);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 17);
		@(negedge clk);
		repeat (gap) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, px};
		s_tuser <= drn;
		cur_typed <= typed;
		cur_eq <= t_eq;
		cur_last <= t_last;
		do @(posedge clk); while (!s_tready);
	endtask

	// drop valid, wait for every expected result, then let the block go idle
	task automatic settle();
		@(negedge clk) s_tvalid <= 1'b0;
		while (pending_eq.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic reg_write(reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk) penable <= 1'b1;
		@(posedge clk);
		apply_reg(idx, val);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [11:0] pick_pixel();
		case ($urandom_range(0, 3))
			0: return 12'($urandom);
			1: return 12'($urandom_range(0, 3));
			2: return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
			default: return 12'($urandom_range(2040, 2056));
		endcase
	endfunction

	// one frame of pixels plus its flush; a broken frame stops early
	task automatic run_frame();
		int unsigned w, total, need, stop;
		w = eff_w();
		total = w * eff_h();
		need = total + cfg_r * w + cfg_r;
		stop = need;
		if (need > 2000) stop = $urandom_range(1, 100);
		else if ($urandom_range(0, 7) == 0) stop = $urandom_range(1, need);
		for (int unsigned i = 0; i < stop; i++) begin
			if (i < total) begin
				if ($urandom_range(0, 15) == 0) put_item(pick_pixel(), 1'b1);
				put_item(pick_pixel(), 1'b0);
			end else begin
				put_item(pick_pixel(), 1'($urandom_range(0, 1)));
			end
			items_sent++;
		end
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3)) put_item(pick_pixel(), 1'b1);
		end
	endtask

	stim_row_t dir_rows [23] = '{
		'{ROW_CFG,   REG_WIDTH,  32'd1,        12'd0,    0, 16'd0, 0},
		'{ROW_CFG,   REG_HEIGHT, 32'd1,        12'd0,    0, 16'd0, 0},
		'{ROW_CFG,   REG_RADIUS, 32'd0,        12'd0,    0, 16'd0, 0},
		'{ROW_CFG,   REG_LEVELS, 32'd256,      12'd0,    0, 16'd0, 0},
		'{ROW_DRAIN, REG_WIDTH,  32'd0,        12'hA5A,  0, 16'd0, 0},
		'{ROW_PIX,   REG_WIDTH,  32'd0,        12'hFFF,  1, 16'd0, 1},
		'{ROW_PIX,   REG_WIDTH,  32'd0,        12'h000,  1, 16'd0, 1},
		'{ROW_CFG,   REG_RADIUS, 32'd1,        12'd0,    0, 16'd0, 0},
		'{ROW_DRAIN, REG_WIDTH,  32'd0,        12'h5A5,  0, 16'd0, 0},
		'{ROW_PIX,   REG_WIDTH,  32'd0,        12'hFFF,  0, 16'd0, 0},
		'{ROW_DRAIN, REG_WIDTH,  32'd0,        12'h000,  0, 16'd0, 0},
		'{ROW_DRAIN, REG_WIDTH,  32'd0,        12'hFFF,  1, 16'd0, 1},
		'{ROW_CFG,   REG_WIDTH,  32'd3,        12'd0,    0, 16'd0, 0},
		'{ROW_CFG,   REG_LEVELS, 32'h10000,    12'd0,    0, 16'd0, 0},
		'{ROW_PIX,   REG_WIDTH,  32'd0,        12'h000,  0, 16'd0, 0},
		'{ROW_PIX,   REG_WIDTH,  32'd0,        12'hFFF,  0, 16'd0, 0},
		'{ROW_PIX,   REG_WIDTH,  32'd0,        12'h001,  0, 16'd0, 0},
		'{ROW_PIX,   REG_WIDTH,  32'd0,        12'h800,  0, 16'd0, 0},
		'{ROW_DRAIN, REG_WIDTH,  32'd0,        12'h000,  0, 16'd0, 0},
		'{ROW_DRAIN, REG_WIDTH,  32'd0,        12'h000,  0, 16'd0, 0},
		'{ROW_DRAIN, REG_WIDTH,  32'd0,        12'h000,  0, 16'd0, 0},
		'{ROW_CFG,   REG_LEVELS, 32'hFFFF_FFFF, 12'd0,   0, 16'd0, 0},
		'{ROW_CFG,   REG_RADIUS, 32'h0000_000F, 12'd0,   0, 16'd0, 0}
	};

	initial begin
		int unsigned start, lv;
		logic [31:0] vals [4];
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cur_typed = 0;
		cur_eq = '0;
		cur_last = 0;
		calm = 0;
		mismatches = 0;
		items_sent = 0;
		cfg_w = RST_WIDTH;
		cfg_h = RST_HEIGHT;
		cfg_r = RST_RADIUS;
		cfg_l = RST_LEVELS;
		restart_frame();
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_rows[i]) begin
			case (dir_rows[i].kind)
				ROW_CFG: begin
					settle();
					reg_write(dir_rows[i].idx, dir_rows[i].value);
				end
				default: begin
					put_item(dir_rows[i].px, dir_rows[i].kind == ROW_DRAIN,
						dir_rows[i].typed, dir_rows[i].t_eq, dir_rows[i].t_last);
				end
			endcase
		end

		// widest image, largest radius, one level: the flush is long, so the frame stops early
		settle();
		reg_write(REG_WIDTH, 32'd2047);
		reg_write(REG_HEIGHT, 32'd0);
		reg_write(REG_LEVELS, 32'd0);
		calm = 1;
		run_frame();

		// tallest image: run a little of it, then drop it
		settle();
		calm = 0;
		reg_write(REG_WIDTH, 32'd1024);
		reg_write(REG_HEIGHT, 32'd65535);
		run_frame();

		items_sent = 0;
		while (items_sent < RAND_ITEMS) begin
			settle();
			vals[0] = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
				: $urandom_range(0, 12);
			vals[1] = ($urandom_range(0, 29) == 0) ? 65535 : $urandom_range(0, 6);
			vals[2] = $urandom_range(0, 7);
			case ($urandom_range(0, 4))
				0: lv = 1;
				1: lv = 2;
				2: lv = 256;
				3: lv = 65536;
				default: lv = $urandom_range(0, 131071);
			endcase
			vals[3] = lv;
			// occasionally set bits above the register's width
			if ($urandom_range(0, 3) == 0) vals[0] |= $urandom & 32'hFFFF_F800;
			if ($urandom_range(0, 3) == 0) vals[2] |= $urandom & 32'hFFFF_FFF8;
			if ($urandom_range(0, 3) == 0) vals[3] |= $urandom & 32'hFFFE_0000;
			start = $urandom_range(0, 3);
			for (int k = 0; k < 4; k++)
				reg_write(reg_idx_t'((start + k) % 4), vals[(start + k) % 4]);
			repeat ($urandom_range(1, 3)) begin
				calm = ($urandom_range(0, 3) == 0);
				run_frame();
			end
		end

		settle();
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
`default_nettype wire
